### hw/rtl/ir_log_ratio_normalize_defines.svh
// Assertion helpers for the IR log-ratio linearizer.
`ifndef IR_LOG_RATIO_NORMALIZE_DEFINES_SVH
`define IR_LOG_RATIO_NORMALIZE_DEFINES_SVH

// Concurrent check on clk_i, off during reset.
`define IRLN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define IRLN_ASSERT_IMPL(lbl, ante, cons, msg) \
  `IRLN_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### hw/rtl/irln_pkg.sv
package irln_pkg;

  localparam int FULL_SCALE_DEF  = 4000;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int SPAN_W    = 16;
  localparam int MANT_W    = 32;
  localparam int LG_W      = 32;
  localparam int FRAC_BITS = 28;
  localparam int LN_W      = 20;
  localparam int NUM_W     = 33;
  localparam int Q_W       = 18;
  localparam int LEVEL_W   = 16;
  localparam int RND_BIT   = 43;
  localparam int RND_SHIFT = 44;

  localparam logic [LG_W-1:0]    LN2_Q32     = 32'hB17217F8;
  localparam logic [SPAN_W-1:0]  S_MIN       = 16'd2;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 16'd64000;
  localparam logic [12:0]        LEVEL_SCALE = 13'd6400;

  typedef struct packed {
    logic [MANT_W-1:0] m;
    logic [LG_W-1:0]   lg;
  } log_t;

  typedef struct packed {
    logic [LN_W-1:0]  r;
    logic [NUM_W-1:0] n;
    logic [LN_W-1:0]  den;
    logic [Q_W-1:0]   q;
  } div_t;

endpackage

### hw/rtl/irln_log_cell.sv
module irln_log_cell (
  input  logic            clk_i,
  input  irln_pkg::log_t  d_i,
  output irln_pkg::log_t  q_o
);

  logic [2*irln_pkg::MANT_W-1:0] sq;
  logic [irln_pkg::MANT_W:0]     t;
  irln_pkg::log_t                cell_d, cell_q;

  always_comb begin
    sq = d_i.m * d_i.m;
    t  = sq[2*irln_pkg::MANT_W-1:irln_pkg::MANT_W-1];
    if (t[irln_pkg::MANT_W]) begin
      cell_d.m  = t[irln_pkg::MANT_W:1];
      cell_d.lg = {d_i.lg[irln_pkg::LG_W-2:0], 1'b1};
    end else begin
      cell_d.m  = t[irln_pkg::MANT_W-1:0];
      cell_d.lg = {d_i.lg[irln_pkg::LG_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign q_o = cell_q;

endmodule

### hw/rtl/irln_div_cell.sv
module irln_div_cell #(
  parameter int BIT = 0
) (
  input  logic            clk_i,
  input  irln_pkg::div_t  d_i,
  output irln_pkg::div_t  q_o
);

  logic [irln_pkg::LN_W:0]   t;
  logic [irln_pkg::LN_W+1:0] diff;
  irln_pkg::div_t            cell_d, cell_q;

  always_comb begin
    t      = {d_i.r, d_i.n[BIT]};
    diff   = {1'b0, t} - {2'b00, d_i.den};
    cell_d = d_i;
    if (diff[irln_pkg::LN_W+1]) begin
      cell_d.r = t[irln_pkg::LN_W-1:0];
      cell_d.q = {d_i.q[irln_pkg::Q_W-2:0], 1'b0};
    end else begin
      cell_d.r = diff[irln_pkg::LN_W-1:0];
      cell_d.q = {d_i.q[irln_pkg::Q_W-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  assign q_o = cell_q;

endmodule

### hw/rtl/ir_log_ratio_normalize.sv
// Linearizes IR distance samples: level = 6400 * ln(Sref) / ln(S) in 1/64 units,
// saturated at 64000. One sample is taken every clock (busy_o stays low) and its
// result appears with valid_o after the front-end register, 28 log squaring cells,
// the product and divide-front registers, 18 restoring divide cells and the output
// register. The receiver cannot stall; each result is present for one cycle only.
// Write reference_sample_i with reference_sample_we_i while no sample is in flight.
`include "ir_log_ratio_normalize_defines.svh"

module ir_log_ratio_normalize #(
  parameter int FULL_SCALE  = irln_pkg::FULL_SCALE_DEF,
  parameter int SAMPLE_BITS = irln_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           reference_sample_we_i,
  input  logic [SAMPLE_BITS-1:0]         reference_sample_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [SAMPLE_BITS-1:0]         adc_sample_i,
  output logic                           valid_o,
  output logic [irln_pkg::LEVEL_W-1:0]   normalized_level_o,
  output logic                           clamped_high_o
);

  localparam int NF  = irln_pkg::FRAC_BITS;
  localparam int NQ  = irln_pkg::Q_W;
  localparam int LAT = 1 + NF + 2 + NQ + 1;
  localparam logic [irln_pkg::SPAN_W-1:0] FS = irln_pkg::SPAN_W'(FULL_SCALE);

  logic [SAMPLE_BITS-1:0] ref_q;
  logic [LAT-1:0]         vld_q, vld_d;

  irln_pkg::log_t smp_chain [NF+1];
  irln_pkg::log_t ref_chain [NF+1];
  irln_pkg::log_t smp_front_d, ref_front_d;
  irln_pkg::div_t div_chain [NQ+1];
  irln_pkg::div_t div_front_d;

  logic [2*irln_pkg::LG_W-1:0] p_smp_q, p_ref_q, p_smp_d, p_ref_d;
  logic [2*irln_pkg::LG_W-1:0] rnd_smp, rnd_ref;
  logic [irln_pkg::LN_W-1:0]   ln_smp, ln_ref;
  logic [irln_pkg::Q_W-1:0]    quo;
  logic [irln_pkg::LEVEL_W-1:0] level_q, level_d;
  logic                         hit_q, hit_d;

  function automatic logic [irln_pkg::SPAN_W-1:0] span(input logic [SAMPLE_BITS-1:0] smp);
    logic [irln_pkg::SPAN_W-1:0] s16;
    logic [irln_pkg::SPAN_W-1:0] s;
    s16 = irln_pkg::SPAN_W'(smp);
    if (s16 >= FS) begin
      s = irln_pkg::S_MIN;
    end else begin
      s = FS - s16;
      if (s < irln_pkg::S_MIN) begin
        s = irln_pkg::S_MIN;
      end
    end
    return s;
  endfunction

  function automatic irln_pkg::log_t norm(input logic [irln_pkg::SPAN_W-1:0] s);
    logic [3:0]     k;
    irln_pkg::log_t r;
    k = 4'd0;
    for (int i = 1; i < irln_pkg::SPAN_W; i++) begin
      if (s[i]) begin
        k = 4'(i);
      end
    end
    r.m  = {s, 16'h0000} << (4'd15 - k);
    r.lg = irln_pkg::LG_W'(k);
    return r;
  endfunction

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0;
      vld_q <= '0;
    end else begin
      if (reference_sample_we_i) begin
        ref_q <= reference_sample_i;
      end
      vld_q <= vld_d;
    end
  end

  assign vld_d = {vld_q[LAT-2:0], start_i & ~busy_o};

  always_comb begin
    smp_front_d = norm(span(adc_sample_i));
    ref_front_d = norm(span(ref_q));
  end

  always_ff @(posedge clk_i) begin
    smp_chain[0] <= smp_front_d;
    ref_chain[0] <= ref_front_d;
  end

  for (genvar g = 0; g < NF; g++) begin : g_log
    irln_log_cell u_smp (.clk_i(clk_i), .d_i(smp_chain[g]), .q_o(smp_chain[g+1]));
    irln_log_cell u_ref (.clk_i(clk_i), .d_i(ref_chain[g]), .q_o(ref_chain[g+1]));
  end

  assign p_smp_d = smp_chain[NF].lg * irln_pkg::LN2_Q32;
  assign p_ref_d = ref_chain[NF].lg * irln_pkg::LN2_Q32;

  always_ff @(posedge clk_i) begin
    p_smp_q <= p_smp_d;
    p_ref_q <= p_ref_d;
  end

  always_comb begin
    rnd_smp = p_smp_q + (64'd1 << irln_pkg::RND_BIT);
    rnd_ref = p_ref_q + (64'd1 << irln_pkg::RND_BIT);
    ln_smp  = rnd_smp[irln_pkg::RND_SHIFT +: irln_pkg::LN_W];
    ln_ref  = rnd_ref[irln_pkg::RND_SHIFT +: irln_pkg::LN_W];
    div_front_d.n   = irln_pkg::NUM_W'(ln_ref) * irln_pkg::NUM_W'(irln_pkg::LEVEL_SCALE);
    div_front_d.den = ln_smp;
    div_front_d.r   = irln_pkg::LN_W'(div_front_d.n[irln_pkg::NUM_W-1:NQ]);
    div_front_d.q   = '0;
  end

  always_ff @(posedge clk_i) begin
    div_chain[0] <= div_front_d;
  end

  for (genvar g = 0; g < NQ; g++) begin : g_div
    irln_div_cell #(.BIT(NQ - 1 - g)) u_div (
      .clk_i(clk_i), .d_i(div_chain[g]), .q_o(div_chain[g+1])
    );
  end

  always_comb begin
    quo = div_chain[NQ].q;
    if (quo > irln_pkg::Q_W'(irln_pkg::LEVEL_MAX)) begin
      level_d = irln_pkg::LEVEL_MAX;
      hit_d   = 1'b1;
    end else begin
      level_d = quo[irln_pkg::LEVEL_W-1:0];
      hit_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    hit_q   <= hit_d;
  end

  assign valid_o            = vld_q[LAT-1];
  assign normalized_level_o = level_q;
  assign clamped_high_o     = hit_q;

  `IRLN_ASSERT_IMPL(a_mant_norm, vld_q[NF], smp_chain[NF].m[irln_pkg::MANT_W-1],
                    "log mantissa lost normalization")
  `IRLN_ASSERT_IMPL(a_rem_bound, vld_q[LAT-2], div_chain[NQ].r < div_chain[NQ].den,
                    "divide remainder not below divisor")
  `IRLN_ASSERT_IMPL(a_level_max, valid_o, normalized_level_o <= irln_pkg::LEVEL_MAX,
                    "level above saturation")
  `IRLN_ASSERT_IMPL(a_clamp_val, valid_o && clamped_high_o,
                    normalized_level_o == irln_pkg::LEVEL_MAX,
                    "clamp flag without saturated level")

endmodule

### sim/tb.sv
module tb;

  localparam int FS      = irln_pkg::FULL_SCALE_DEF;
  localparam int SBITS   = irln_pkg::SAMPLE_BITS_DEF;
  localparam int LATENCY = 50;
  localparam int WDOG    = 5000;

  typedef struct {
    logic [irln_pkg::LEVEL_W-1:0] level;
    logic                         clamped;
  } level_t;

  typedef struct {
    logic [SBITS-1:0]             sample;
    bit                           typed;
    logic [irln_pkg::LEVEL_W-1:0] level;
    logic                         clamped;
  } stim_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         reference_sample_we_i = 1'b0;
  logic [SBITS-1:0]             reference_sample_i = '0;
  logic                         start_i = 1'b0;
  logic                         busy_o;
  logic [SBITS-1:0]             adc_sample_i = '0;
  logic                         valid_o;
  logic [irln_pkg::LEVEL_W-1:0] normalized_level_o;
  logic                         clamped_high_o;

  logic [SBITS-1:0] ref_reg;
  level_t           level_q[$];
  int               mismatches = 0;
  int               idle_cycles = 0;

  ir_log_ratio_normalize DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .reference_sample_we_i(reference_sample_we_i),
    .reference_sample_i(reference_sample_i),
    .start_i(start_i),
    .busy_o(busy_o),
    .adc_sample_i(adc_sample_i),
    .valid_o(valid_o),
    .normalized_level_o(normalized_level_o),
    .clamped_high_o(clamped_high_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [15:0] span_of(input logic [SBITS-1:0] s);
    int t;
    if (int'(s) >= FS) return 16'(irln_pkg::S_MIN);
    t = FS - int'(s);
    if (t < int'(irln_pkg::S_MIN)) t = int'(irln_pkg::S_MIN);
    return 16'(t);
  endfunction

  function automatic logic [63:0] ln_fix(input logic [15:0] x);
    int          k;
    logic [63:0] m;
    logic [63:0] lg;
    logic [63:0] p;
    k = 0;
    if (x < 16'd2) x = 16'd2;
    while (k < 15 && (x >> (k + 1)) != 0) k++;
    m = 64'(x) << (31 - k);
    lg = 64'(k);
    for (int i = 0; i < irln_pkg::FRAC_BITS; i++) begin
      m = (m * m) >> 31;
      lg = lg << 1;
      if (m >= 64'h1_0000_0000) begin
        lg = lg | 64'd1;
        m = m >> 1;
      end
    end
    p = lg * 64'(irln_pkg::LN2_Q32);
    return (p + (64'd1 << irln_pkg::RND_BIT)) >> irln_pkg::RND_SHIFT;
  endfunction

  function automatic level_t linearize(input logic [SBITS-1:0] rs, input logic [SBITS-1:0] s);
    logic [63:0] q;
    level_t      r;
    q = (64'd6400 * ln_fix(span_of(rs))) / ln_fix(span_of(s));
    r.clamped = (q > 64'(irln_pkg::LEVEL_MAX));
    r.level = r.clamped ? irln_pkg::LEVEL_MAX : q[irln_pkg::LEVEL_W-1:0];
    return r;
  endfunction

  task automatic send(input logic [SBITS-1:0] s, input level_t e);
    start_i <= 1'b1;
    adc_sample_i <= s;
    do @(posedge clk_i); while (busy_o);
    level_q.push_back(e);
  endtask

  task automatic pause(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (level_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_ref(input logic [SBITS-1:0] v);
    reference_sample_we_i <= 1'b1;
    reference_sample_i <= v;
    @(posedge clk_i);
    reference_sample_we_i <= 1'b0;
    ref_reg = v;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    level_t e;
    if (rst_ni && valid_o) begin
      if (level_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result level=%0d clamped=%0b",
                                       normalized_level_o, clamped_high_o);
      end else begin
        e = level_q.pop_front();
        if (normalized_level_o !== e.level || clamped_high_o !== e.clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp level=%0d clamped=%0b, got level=%0d clamped=%0b",
                     e.level, e.clamped, normalized_level_o, clamped_high_o);
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    stim_row_t        rows[$];
    stim_row_t        r;
    level_t           e;
    logic [SBITS-1:0] refs[$];
    logic [SBITS-1:0] s;
    int               sel;
    int               n;
    ref_reg = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reference 0 after reset: Sref = full scale
    rows.push_back('{12'd0, 1, 16'd6400, 1'b0});
    rows.push_back('{12'd4095, 1, irln_pkg::LEVEL_MAX, 1'b1});
    rows.push_back('{12'd4000, 1, irln_pkg::LEVEL_MAX, 1'b1});
    rows.push_back('{12'd3999, 1, irln_pkg::LEVEL_MAX, 1'b1});
    rows.push_back('{12'd3998, 1, irln_pkg::LEVEL_MAX, 1'b1});
    rows.push_back('{12'd3997, 0, '0, 1'b0});
    rows.push_back('{12'd1, 0, '0, 1'b0});
    rows.push_back('{12'd2048, 0, '0, 1'b0});
    rows.push_back('{12'd2047, 0, '0, 1'b0});
    rows.push_back('{12'd3900, 0, '0, 1'b0});
    rows.push_back('{12'd3990, 0, '0, 1'b0});
    rows.push_back('{12'd1000, 0, '0, 1'b0});
    rows.push_back('{12'hAAA, 0, '0, 1'b0});
    rows.push_back('{12'h555, 0, '0, 1'b0});
    foreach (rows[i]) begin
      r = rows[i];
      e = r.typed ? level_t'{r.level, r.clamped} : linearize(ref_reg, r.sample);
      send(r.sample, e);
      if (i % 3 == 2) pause(1 + $urandom_range(0, 3));
    end
    drain();

    refs = {12'd4095, 12'd3999, 12'd3998, 12'd2000, 12'd1, 12'd0,
            12'($urandom_range(0, 4095)), 12'($urandom_range(3900, 4095))};
    foreach (refs[p]) begin
      write_ref(refs[p]);
      n = 125;
      for (int i = 0; i < n; i++) begin
        sel = $urandom_range(0, 9);
        if (sel < 6) s = 12'($urandom_range(0, 4095));
        else if (sel < 8) s = 12'($urandom_range(3980, 4095));
        else s = 12'($urandom_range(0, 12));
        send(s, linearize(ref_reg, s));
        if (p != 3 && $urandom_range(0, 99) < 28) pause(1);
      end
      drain();
    end

    if (mismatches == 0 && level_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
